>>> design/pcc_pkg.sv
// shared types and codes for the correlation accumulator
`timescale 1ns / 1ps
`default_nettype none
package pcc_pkg;
   localparam int MAX_PAIRS_DEFAULT   = 1024;
   localparam int SAMPLE_BITS_DEFAULT = 16;

   localparam logic [3:0] OP_NXX = 4'd0;
   localparam logic [3:0] OP_XX  = 4'd1;
   localparam logic [3:0] OP_NYY = 4'd2;
   localparam logic [3:0] OP_YY  = 4'd3;
   localparam logic [3:0] OP_NXY = 4'd4;
   localparam logic [3:0] OP_XY  = 4'd5;
   localparam logic [3:0] OP_VV  = 4'd6;
   localparam logic [3:0] OP_CC  = 4'd7;
   localparam logic [3:0] OP_DP  = 4'd8;

   typedef struct packed {
      logic       acc;
      logic       load;
      logic       store;
      logic       check;
      logic       mid;
      logic       finish;
      logic [3:0] op;
   } cmd_type;

   typedef struct packed {
      logic mul_busy;
      logic degen;
      logic search_done;
   } status_type;
endpackage
`default_nettype wire

>>> design/pcc_ctrl.sv
// sequencing state machine for the correlation accumulator
`timescale 1ns / 1ps
`default_nettype none
module pcc_ctrl (
   input  wire                  clock,
   input  wire                  reset,
   input  wire                  req_valid,
   input  wire                  req_last_pair,
   output logic                 req_ready,
   output logic                 rsp_valid,
   input  wire                  rsp_ready,
   input  pcc_pkg::status_type  status,
   output pcc_pkg::cmd_type     cmd
);
   localparam logic [2:0] S_ACC    = 3'd0;
   localparam logic [2:0] S_LOAD   = 3'd1;
   localparam logic [2:0] S_RUN    = 3'd2;
   localparam logic [2:0] S_STORE  = 3'd3;
   localparam logic [2:0] S_CHECK  = 3'd4;
   localparam logic [2:0] S_SRCH   = 3'd5;
   localparam logic [2:0] S_FINISH = 3'd6;

   logic [2:0] state_ff, state_in;
   logic [3:0] op_ff, op_in;
   logic       valid_ff, valid_in;

   always_comb begin
      state_in   = state_ff;
      op_in      = op_ff;
      cmd        = '0;
      cmd.op     = op_ff;
      req_ready  = (state_ff == S_ACC);
      cmd.acc    = req_valid && req_ready;
      case (state_ff)
         S_ACC: begin
            if (req_valid && req_last_pair) begin
               op_in    = pcc_pkg::OP_NXX;
               state_in = S_LOAD;
            end
         end
         S_LOAD: begin
            cmd.load = 1'b1;
            state_in = S_RUN;
         end
         S_RUN: begin
            if (!status.mul_busy) state_in = S_STORE;
         end
         S_STORE: begin
            cmd.store = 1'b1;
            if (op_ff == pcc_pkg::OP_XY) begin
               state_in = S_CHECK;
            end else if (op_ff == pcc_pkg::OP_CC || op_ff == pcc_pkg::OP_DP) begin
               state_in = S_SRCH;
            end else begin
               op_in    = op_ff + 4'd1;
               state_in = S_LOAD;
            end
         end
         S_CHECK: begin
            cmd.check = 1'b1;
            if (status.degen) begin
               state_in = S_FINISH;
            end else begin
               op_in    = pcc_pkg::OP_VV;
               state_in = S_LOAD;
            end
         end
         S_SRCH: begin
            if (status.search_done) begin
               state_in = S_FINISH;
            end else begin
               cmd.mid  = 1'b1;
               op_in    = pcc_pkg::OP_DP;
               state_in = S_LOAD;
            end
         end
         S_FINISH: begin
            if (!valid_ff || rsp_ready) begin
               cmd.finish = 1'b1;
               state_in   = S_ACC;
            end
         end
         default: state_in = S_ACC;
      endcase
      valid_in = cmd.finish ? 1'b1 : (rsp_ready ? 1'b0 : valid_ff);
   end

   assign rsp_valid = valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_ACC;
         op_ff    <= pcc_pkg::OP_NXX;
         valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         op_ff    <= op_in;
         valid_ff <= valid_in;
      end
   end

   a_one_cmd: assert property (@(posedge clock) disable iff (reset)
      $onehot0({cmd.load, cmd.store, cmd.check, cmd.mid, cmd.finish}))
      else $error("more than one datapath command");
   a_finish_valid: assert property (@(posedge clock) disable iff (reset)
      cmd.finish |=> valid_ff)
      else $error("result not presented after finish");
   a_run_store: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_RUN && !status.mul_busy) |=> cmd.store)
      else $error("product not stored");
   a_no_req_busy: assert property (@(posedge clock) disable iff (reset)
      (state_ff != S_ACC) |-> !cmd.acc)
      else $error("request taken during computation");
endmodule
`default_nettype wire

>>> design/pcc_mult.sv
// shift-add serial multiplier, one multiplier bit per cycle
`timescale 1ns / 1ps
`default_nettype none
module pcc_mult #(
   parameter int AW = 64,
   parameter int BW = 32
) (
   input  wire              clock,
   input  wire              reset,
   input  wire              start,
   input  wire  [AW-1:0]    a,
   input  wire  [BW-1:0]    b,
   output logic             busy,
   output logic [AW+BW-1:0] prod
);
   localparam int PRW = AW + BW;
   localparam int CNW = $clog2(BW + 1);

   logic [PRW-1:0] a_ff, acc_ff;
   logic [BW-1:0]  b_ff;
   logic [CNW-1:0] cnt_ff;
   logic           busy_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else if (start) begin
         busy_ff <= 1'b1;
         cnt_ff  <= CNW'(BW);
      end else if (busy_ff) begin
         cnt_ff  <= cnt_ff - CNW'(1);
         busy_ff <= (cnt_ff != CNW'(1));
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         a_ff   <= PRW'(a);
         b_ff   <= b;
         acc_ff <= '0;
      end else if (busy_ff) begin
         if (b_ff[0]) acc_ff <= acc_ff + a_ff;
         a_ff <= {a_ff[PRW-2:0], 1'b0};
         b_ff <= {1'b0, b_ff[BW-1:1]};
      end
   end

   assign busy = busy_ff;
   assign prod = acc_ff;
endmodule
`default_nettype wire

>>> design/pcc_dpath.sv
// accumulators, variance terms and coefficient search datapath
`timescale 1ns / 1ps
`default_nettype none
module pcc_dpath #(
   parameter int MAX_PAIRS   = pcc_pkg::MAX_PAIRS_DEFAULT,
   parameter int SAMPLE_BITS = pcc_pkg::SAMPLE_BITS_DEFAULT
) (
   input  wire                     clock,
   input  wire                     reset,
   input  wire  signed [15:0]      req_x_sample,
   input  wire  signed [15:0]      req_y_sample,
   input  pcc_pkg::cmd_type        cmd,
   output pcc_pkg::status_type     status,
   output logic signed [15:0]      rsp_coefficient,
   output logic                    rsp_degenerate
);
   localparam int SW  = SAMPLE_BITS;
   localparam int CW  = $clog2(MAX_PAIRS + 1);
   localparam int S1W = SW + CW;
   localparam int S2W = 2 * SW + CW;
   localparam int VW  = 2 * SW + 2 * CW + 2;
   localparam int AW  = 2 * VW;
   localparam int BW  = (VW > 32) ? VW : 32;
   localparam int PRW = AW + BW;

   logic signed [SW-1:0] xs, ys;

   generate
      if (SW <= 16) begin : g_narrow
         assign xs = req_x_sample[SW-1:0];
         assign ys = req_y_sample[SW-1:0];
      end else begin : g_wide
         assign xs = {{(SW-16){1'b0}}, req_x_sample};
         assign ys = {{(SW-16){1'b0}}, req_y_sample};
      end
   endgenerate

   logic [CW-1:0]         n_ff;
   logic signed [S1W-1:0] sx_ff, sy_ff;
   logic [S2W-1:0]        sxx_ff, syy_ff;
   logic signed [S2W-1:0] sxy_ff;
   logic signed [2*SW-1:0] xx, yy, xy;

   assign xx = xs * xs;
   assign yy = ys * ys;
   assign xy = xs * ys;

   always_ff @(posedge clock) begin
      if (reset || cmd.finish) begin
         n_ff   <= '0;
         sx_ff  <= '0;
         sy_ff  <= '0;
         sxx_ff <= '0;
         syy_ff <= '0;
         sxy_ff <= '0;
      end else if (cmd.acc && (n_ff < CW'(MAX_PAIRS))) begin
         n_ff   <= n_ff + CW'(1);
         sx_ff  <= sx_ff + S1W'(xs);
         sy_ff  <= sy_ff + S1W'(ys);
         sxx_ff <= sxx_ff + S2W'($unsigned(xx));
         syy_ff <= syy_ff + S2W'($unsigned(yy));
         sxy_ff <= sxy_ff + S2W'(xy);
      end
   end

   logic [S1W-1:0] sx_mag, sy_mag;
   logic [S2W-1:0] sxy_mag;

   assign sx_mag  = sx_ff[S1W-1] ? S1W'(-sx_ff) : S1W'(sx_ff);
   assign sy_mag  = sy_ff[S1W-1] ? S1W'(-sy_ff) : S1W'(sy_ff);
   assign sxy_mag = sxy_ff[S2W-1] ? S2W'(-sxy_ff) : S2W'(sxy_ff);

   logic signed [VW-1:0] t_ff, vx_ff, vy_ff, cov_ff;
   logic [VW-1:0]        cov_mag_ff;
   logic                 neg_ff;
   logic [AW-1:0]        p_ff, cc_ff;
   logic [15:0]          lo_ff, hi_ff, mid_ff;
   logic [31:0]          d2_ff;
   logic signed [15:0]   coef_ff;
   logic                 degen_ff;

   logic [AW-1:0]  mul_a;
   logic [BW-1:0]  mul_b;
   logic           mul_neg;
   logic [PRW-1:0] prod;
   logic [VW-1:0]  prod_mag;
   logic signed [VW-1:0] prod_val;
   logic [PRW-1:0] rhs;
   logic [16:0]    mid_sum;
   logic [15:0]    mid_next, d_next;
   logic [15:0]    sat;

   always_comb begin
      mul_a   = '0;
      mul_b   = '0;
      mul_neg = 1'b0;
      case (cmd.op)
         pcc_pkg::OP_NXX: begin
            mul_a = AW'(sxx_ff);
            mul_b = BW'(n_ff);
         end
         pcc_pkg::OP_XX: begin
            mul_a = AW'(sx_mag);
            mul_b = BW'(sx_mag);
         end
         pcc_pkg::OP_NYY: begin
            mul_a = AW'(syy_ff);
            mul_b = BW'(n_ff);
         end
         pcc_pkg::OP_YY: begin
            mul_a = AW'(sy_mag);
            mul_b = BW'(sy_mag);
         end
         pcc_pkg::OP_NXY: begin
            mul_a   = AW'(sxy_mag);
            mul_b   = BW'(n_ff);
            mul_neg = sxy_ff[S2W-1];
         end
         pcc_pkg::OP_XY: begin
            mul_a   = AW'(sx_mag);
            mul_b   = BW'(sy_mag);
            mul_neg = sx_ff[S1W-1] ^ sy_ff[S1W-1];
         end
         pcc_pkg::OP_VV: begin
            mul_a = AW'($unsigned(vx_ff));
            mul_b = BW'($unsigned(vy_ff));
         end
         pcc_pkg::OP_CC: begin
            mul_a = AW'(cov_mag_ff);
            mul_b = BW'(cov_mag_ff);
         end
         pcc_pkg::OP_DP: begin
            mul_a = p_ff;
            mul_b = BW'(d2_ff);
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   pcc_mult #(.AW(AW), .BW(BW)) u_mult (
      .clock (clock),
      .reset (reset),
      .start (cmd.load),
      .a     (mul_a),
      .b     (mul_b),
      .busy  (status.mul_busy),
      .prod  (prod)
   );

   assign prod_mag = prod[VW-1:0];
   assign prod_val = mul_neg ? $signed(~prod_mag + VW'(1)) : $signed(prod_mag);
   assign rhs      = PRW'({cc_ff, 32'd0});
   assign mid_sum  = 17'(lo_ff) + 17'(hi_ff) + 17'd1;
   assign mid_next = mid_sum[16:1];
   assign d_next   = 16'({mid_next, 1'b0} - 17'd1);
   assign sat      = (!neg_ff && lo_ff[15]) ? 16'h7fff : lo_ff;

   always_ff @(posedge clock) begin
      if (cmd.store) begin
         case (cmd.op)
            pcc_pkg::OP_NXX, pcc_pkg::OP_NYY, pcc_pkg::OP_NXY: t_ff <= prod_val;
            pcc_pkg::OP_XX: vx_ff  <= t_ff - prod_val;
            pcc_pkg::OP_YY: vy_ff  <= t_ff - prod_val;
            pcc_pkg::OP_XY: cov_ff <= t_ff - prod_val;
            pcc_pkg::OP_VV: p_ff   <= prod[AW-1:0];
            pcc_pkg::OP_CC: cc_ff  <= prod[AW-1:0];
            pcc_pkg::OP_DP: begin
               if (prod <= rhs) lo_ff <= mid_ff;
               else hi_ff <= mid_ff - 16'd1;
            end
            default: t_ff <= t_ff;
         endcase
      end
      if (cmd.check) begin
         neg_ff     <= cov_ff[VW-1];
         cov_mag_ff <= cov_ff[VW-1] ? VW'(-cov_ff) : VW'(cov_ff);
         lo_ff      <= 16'd0;
         hi_ff      <= 16'h8000;
      end
      if (cmd.mid) begin
         mid_ff <= mid_next;
         d2_ff  <= d_next * d_next;
      end
      if (cmd.finish) begin
         degen_ff <= status.degen;
         coef_ff  <= status.degen ? 16'sd0 : (neg_ff ? $signed(~lo_ff + 16'd1) : $signed(sat));
      end
   end

   assign status.degen       = (vx_ff[VW-1] || vx_ff == '0 || vy_ff[VW-1] || vy_ff == '0);
   assign status.search_done = (lo_ff >= hi_ff);
   assign rsp_coefficient    = coef_ff;
   assign rsp_degenerate     = degen_ff;
endmodule
`default_nettype wire

>>> design/pearson_correlation_accumulator_core.sv
// top level of the pearson correlation accumulator
// after the last pair the controller runs up to 8 term multiplies and up to 16 search
// steps on a serial multiplier of width BW before the result is valid,
// BW = max(VW, 32), VW = 2*SAMPLE_BITS + 2*clog2(MAX_PAIRS+1) + 2
// throughput: one request per cycle between series; none taken while computing
// reset: synchronous, clears the count, sums, controller state and result valid
`timescale 1ns / 1ps
`default_nettype none
module pearson_correlation_accumulator_core #(
   parameter int MAX_PAIRS   = pcc_pkg::MAX_PAIRS_DEFAULT,
   parameter int SAMPLE_BITS = pcc_pkg::SAMPLE_BITS_DEFAULT
) (
   input  wire                 clock,
   input  wire                 reset,
   input  wire                 req_valid,
   output logic                req_ready,
   input  wire  signed [15:0]  req_x_sample,
   input  wire  signed [15:0]  req_y_sample,
   input  wire                 req_last_pair,
   output logic                rsp_valid,
   input  wire                 rsp_ready,
   output logic signed [15:0]  rsp_coefficient,
   output logic                rsp_degenerate
);
   pcc_pkg::cmd_type    cmd;
   pcc_pkg::status_type status;

   pcc_ctrl u_ctrl (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_last_pair (req_last_pair),
      .req_ready     (req_ready),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .status        (status),
      .cmd           (cmd)
   );

   pcc_dpath #(.MAX_PAIRS(MAX_PAIRS), .SAMPLE_BITS(SAMPLE_BITS)) u_dpath (
      .clock           (clock),
      .reset           (reset),
      .req_x_sample    (req_x_sample),
      .req_y_sample    (req_y_sample),
      .cmd             (cmd),
      .status          (status),
      .rsp_coefficient (rsp_coefficient),
      .rsp_degenerate  (rsp_degenerate)
   );
endmodule
`default_nettype wire
